// ===== sv/length_prefixed_packet_deframer_core_defines.svh =====
// Assertion macros shared by the deframer checker.
// No dependencies; include guarded.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define LPPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lppd_pkg.sv =====
// Package for the length-prefixed packet deframer: payload structs, codes, config.
// No dependencies.
`timescale 1ns / 1ps

package lppd_pkg;

    localparam int unsigned HeaderBytes = 8;
    localparam int unsigned WordBytes   = 4;
    localparam int unsigned CfgAddrW    = 3;

    typedef enum logic [2:0] {
        K_HEADER     = 3'd0,
        K_PAYLOAD    = 3'd1,
        K_DISCONNECT = 3'd2,
        K_BAD_MARK   = 3'd3,
        K_OVERSIZE   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_MARK    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_HALT    = 3'd4
    } phase_t;

    typedef enum logic {
        CMD_DATA       = 1'b0,
        CMD_DISCONNECT = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_MARK    = 1'b0,
        REG_MAX_LEN = 1'b1
    } reg_idx_t;

    localparam logic [31:0] MarkReset   = 32'd0;
    localparam logic [31:0] MaxLenReset = 32'd65536;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] packet_type;
        logic [31:0] data_length;
        logic [7:0]  payload_byte;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] mark;
        logic [31:0] max_len;
    } cfg_t;

endpackage

// ===== sv/length_prefixed_packet_deframer_core.sv =====
// Path: an accepted transfer waits in the input register until the result
// register is free, then is decoded into it. Throughput: one input transfer
// per cycle unless out_ready stalls; the parser decodes one byte per cycle.
// Reset: rst_n asynchronous, active low; clears both pipeline stages, the parser
// state (awaiting byte-order mark) and the registers (mark 0, max length 65536).
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lppd_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lppd_pkg::out_item_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lppd_pkg::CfgAddrW-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lppd_pkg::*;

    cfg_t      cfg;
    in_item_t  item;
    logic      item_valid;
    logic      take;
    logic      out_free;
    logic      res_valid;
    out_item_t res;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    lppd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lppd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    lppd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign take     = item_valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/lppd_cfg.sv =====
// APB-style register file: byte-order mark and maximum packet length.
// Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lppd_pkg::CfgAddrW-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output lppd_pkg::cfg_t                  cfg
);
    import lppd_pkg::*;

    logic [31:0] mark_reg;
    logic [31:0] max_len_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg    <= MarkReset;
            max_len_reg <= MaxLenReset;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MARK:    mark_reg    <= pwdata;
                REG_MAX_LEN: max_len_reg <= pwdata;
                default:     mark_reg    <= mark_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MARK:    prdata = mark_reg;
            REG_MAX_LEN: prdata = max_len_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.mark    = mark_reg;
    assign cfg.max_len = max_len_reg;

endmodule

// ===== sv/lppd_in_stage.sv =====
// Input register: holds one accepted transfer until the parser takes it.
// Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lppd_pkg::in_item_t in_data,
    input  logic               take,
    output logic               item_valid,
    output lppd_pkg::in_item_t item
);
    import lppd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= in_data;
    end

endmodule

// ===== sv/lppd_parser.sv =====
// Deframing state machine: mark check, header word assembly, payload count.
// Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lppd_pkg::in_item_t  item,
    input  lppd_pkg::cfg_t      cfg,
    output logic                res_valid,
    output lppd_pkg::out_item_t res
);
    import lppd_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [1:0]  biw_reg,     biw_next;
    logic [31:0] shift_reg,   shift_next;
    logic [31:0] len_reg,     len_next;
    logic [31:0] type_reg,    type_next;
    logic [31:0] rem_reg,     rem_next;
    logic [31:0] word;
    logic        word_done;
    logic        oversize;

    assign word      = {shift_reg[23:0], item.data_byte};
    assign word_done = (biw_reg == 2'(WordBytes - 1));
    assign oversize  = ({1'b0, word} + 33'(HeaderBytes)) > {1'b0, cfg.max_len};

    always_comb
    begin
        phase_next = phase_reg;
        biw_next   = biw_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = K_HEADER;

        if (step)
        begin
            if (cmd_t'(item.command) == CMD_DISCONNECT)
            begin
                phase_next = PH_MARK;
                biw_next   = '0;
                shift_next = '0;
                len_next   = '0;
                type_next  = '0;
                rem_next   = '0;
                res_valid  = 1'b1;
                res.kind   = K_DISCONNECT;
                res.last   = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_HALT:
                    begin
                        phase_next = PH_HALT;
                    end
                    PH_PAYLOAD:
                    begin
                        rem_next         = rem_reg - 32'd1;
                        res_valid        = 1'b1;
                        res.kind         = K_PAYLOAD;
                        res.packet_type  = type_reg;
                        res.data_length  = len_reg;
                        res.payload_byte = item.data_byte;
                        res.last         = (rem_reg == 32'd1);
                        if (rem_reg == 32'd1)
                            phase_next = PH_LENGTH;
                    end
                    PH_MARK, PH_LENGTH, PH_TYPE:
                    begin
                        biw_next = biw_reg + 2'd1;
                        if (!word_done)
                            shift_next = word;
                        else
                        begin
                            shift_next = '0;
                            case (phase_reg)
                                PH_MARK:
                                begin
                                    if (word != cfg.mark)
                                    begin
                                        phase_next = PH_HALT;
                                        res_valid  = 1'b1;
                                        res.kind   = K_BAD_MARK;
                                    end
                                    else
                                        phase_next = PH_LENGTH;
                                end
                                PH_LENGTH:
                                begin
                                    len_next = word;
                                    if (oversize)
                                    begin
                                        phase_next      = PH_HALT;
                                        res_valid       = 1'b1;
                                        res.kind        = K_OVERSIZE;
                                        res.data_length = word;
                                    end
                                    else
                                        phase_next = PH_TYPE;
                                end
                                default:
                                begin
                                    type_next       = word;
                                    res_valid       = 1'b1;
                                    res.kind        = K_HEADER;
                                    res.packet_type = word;
                                    res.data_length = len_reg;
                                    if (len_reg == 32'd0)
                                    begin
                                        phase_next = PH_LENGTH;
                                        res.last   = 1'b1;
                                    end
                                    else
                                    begin
                                        rem_next   = len_reg;
                                        phase_next = PH_PAYLOAD;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MARK;
            biw_reg   <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            biw_reg   <= biw_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== sv/lppd_checker.sv =====
// Port-level checker for the deframer core, bound to the top level.
// Depends on lppd_pkg and length_prefixed_packet_deframer_core_defines.svh.
`timescale 1ns / 1ps
`include "length_prefixed_packet_deframer_core_defines.svh"

module lppd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input lppd_pkg::out_item_t out_data,
    input logic                pready
);
    import lppd_pkg::*;

    `LPPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result transfer changed")
    `LPPD_ASSERT_NOW(a_disc_fields, clk, rst_n, out_valid && out_data.kind == K_DISCONNECT, out_data.last && out_data.packet_type == 32'd0 && out_data.data_length == 32'd0, "disconnect result fields wrong")
    `LPPD_ASSERT_NOW(a_err_not_last, clk, rst_n, out_valid && (out_data.kind == K_BAD_MARK || out_data.kind == K_OVERSIZE), !out_data.last && out_data.packet_type == 32'd0, "error result fields wrong")
    `LPPD_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready, "pready dropped")

endmodule

bind length_prefixed_packet_deframer_core lppd_checker u_lppd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);

// ===== tb/length_prefixed_packet_deframer_core_tb.sv =====
// Self-checking testbench for the length-prefixed packet deframer core: directed and
// random byte streams with APB register writes, checked against an internal predictor.
// Depends on lppd_pkg and length_prefixed_packet_deframer_core.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core_tb;
    import lppd_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int ReportLimit  = 10;
    localparam int SettleCycles = 4;

    class deframer_scoreboard;
        logic [31:0] mark;
        logic [31:0] max_len;
        phase_t      phase;
        logic [1:0]  byte_cnt;
        logic [31:0] shift_word;
        logic [31:0] cur_len;
        logic [31:0] cur_type;
        logic [31:0] remaining;
        out_item_t   pending_results[$];
        int          faults;

        function new();
            mark    = MarkReset;
            max_len = MaxLenReset;
            faults  = 0;
            rearm();
        endfunction

        function void rearm();
            phase      = PH_MARK;
            byte_cnt   = '0;
            shift_word = '0;
            cur_len    = '0;
            cur_type   = '0;
            remaining  = '0;
        endfunction

        function bit halted();
            return phase == PH_HALT;
        endfunction

        function void expect_result(out_item_t r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void absorb_transfer(in_item_t it);
            out_item_t   r;
            logic [31:0] w;
            r = '0;
            if (it.command == CMD_DISCONNECT)
            begin
                rearm();
                r.kind = K_DISCONNECT;
                r.last = 1'b1;
                expect_result(r);
                return;
            end
            if (phase == PH_HALT)
                return;
            if (phase == PH_PAYLOAD)
            begin
                remaining--;
                r.kind         = K_PAYLOAD;
                r.packet_type  = cur_type;
                r.data_length  = cur_len;
                r.payload_byte = it.data_byte;
                if (remaining == 0)
                begin
                    r.last = 1'b1;
                    phase  = PH_LENGTH;
                end
                expect_result(r);
                return;
            end
            shift_word = {shift_word[23:0], it.data_byte};
            byte_cnt++;
            if (byte_cnt != 0)
                return;
            w          = shift_word;
            shift_word = '0;
            case (phase)
                PH_MARK:
                begin
                    if (w != mark)
                    begin
                        phase  = PH_HALT;
                        r.kind = K_BAD_MARK;
                        expect_result(r);
                    end
                    else
                        phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    cur_len = w;
                    if (64'(w) + 64'(HeaderBytes) > 64'(max_len))
                    begin
                        phase         = PH_HALT;
                        r.kind        = K_OVERSIZE;
                        r.data_length = w;
                        expect_result(r);
                    end
                    else
                        phase = PH_TYPE;
                end
                default:
                begin
                    cur_type      = w;
                    r.kind        = K_HEADER;
                    r.packet_type = w;
                    r.data_length = cur_len;
                    if (cur_len == 0)
                    begin
                        phase  = PH_LENGTH;
                        r.last = 1'b1;
                    end
                    else
                    begin
                        remaining = cur_len;
                        phase     = PH_PAYLOAD;
                    end
                    expect_result(r);
                end
            endcase
        endfunction

        function void compare_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                faults++;
                if (faults <= ReportLimit)
                    $display("unexpected result: kind=%0d type=%h len=%h byte=%h last=%b",
                             got.kind, got.packet_type, got.data_length, got.payload_byte,
                             got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.packet_type !== want.packet_type ||
                got.data_length !== want.data_length ||
                got.payload_byte !== want.payload_byte || got.last !== want.last)
            begin
                faults++;
                if (faults <= ReportLimit)
                begin
                    $display("mismatch: exp kind=%0d type=%h len=%h byte=%h last=%b",
                             want.kind, want.packet_type, want.data_length,
                             want.payload_byte, want.last);
                    $display("          got kind=%0d type=%h len=%h byte=%h last=%b",
                             got.kind, got.packet_type, got.data_length,
                             got.payload_byte, got.last);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    bit                  idling;
    int                  hold_request;
    int                  counted_items;
    deframer_scoreboard  sb;

    length_prefixed_packet_deframer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int cyc;
        for (cyc = 0; cyc < CycleLimit; cyc++)
            @(posedge clk);
        $display("[length_prefixed_packet_deframer_core] ERROR");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.compare_result(out_data);
    end

    task automatic send_item(cmd_t cmd, logic [7:0] b);
        in_item_t it;
        it.command   = cmd;
        it.data_byte = b;
        if (cmd == CMD_DISCONNECT || !sb.halted())
            counted_items++;
        @(negedge clk);
        if (idling && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.absorb_transfer(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_DATA, b);
    endtask

    task automatic send_disconnect();
        send_item(CMD_DISCONNECT, 8'($urandom));
    endtask

    // big-endian: most significant byte first
    task automatic send_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MARK)
            sb.mark = value;
        else
            sb.max_len = value;
    endtask

    task automatic send_packet(output bit alive);
        longint      room;
        longint      lo;
        logic [31:0] len;
        int          r;
        int          nbytes;
        room  = longint'(sb.max_len) - longint'(HeaderBytes);
        r     = $urandom_range(0, 99);
        alive = 1'b1;
        if (r < 3)
        begin
            // broken header, cut off by the disconnect that follows
            repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
            alive = 1'b0;
            return;
        end
        if (room < 0 || r < 12)
        begin
            lo  = (room < 0) ? 0 : room + 1;
            len = $urandom_range(0, 1) ? 32'(lo)
                                       : 32'($urandom_range(32'(lo), 32'hFFFF_FFFF));
            send_word(len);
            alive = 1'b0;
            return;
        end
        if (r < 20)
            len = (room > 16 && $urandom_range(0, 1)) ? 32'(room)
                                                       : 32'($urandom_range(0, 32'(room)));
        else if (r < 30)
            len = '0;
        else
            len = (room >= 1) ? 32'($urandom_range(1, (room < 12) ? 32'(room) : 12)) : '0;
        send_word(len);
        send_word($urandom);
        nbytes = (len > 16) ? $urandom_range(0, 8) : int'(len);
        repeat (nbytes) send_byte(8'($urandom));
        alive = (nbytes == len);
    endtask

    task automatic run_session();
        logic [31:0] m;
        bit          alive;
        int          npk;
        int          pick;
        m    = sb.mark;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            m[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
        if (pick == 1)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            send_disconnect();
            return;
        end
        send_word(m);
        npk   = $urandom_range(1, 6);
        alive = !sb.halted();
        while (alive && npk > 0)
        begin
            send_packet(alive);
            npk--;
        end
        if (sb.halted())
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
        send_disconnect();
    endtask

    task automatic run_until(int target);
        while (counted_items < target)
            run_session();
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idling        = 1'b0;
        hold_request  = 0;
        counted_items = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        send_disconnect();
        send_word(32'h0000_00FF);
        send_byte(8'hAA);
        send_disconnect();
        send_word(MarkReset);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_disconnect();
        wait_for_results();

        idling = 1'b1;
        cfg_write(REG_MARK, $urandom);
        cfg_write(REG_MAX_LEN, MaxLenReset);
        run_until(180);
        hold_request = 250;
        run_until(330);
        wait_for_results();
        run_until(480);
        wait_for_results();

        cfg_write(REG_MARK, 32'hFFFF_FFFF);
        cfg_write(REG_MAX_LEN, 32'hFFFF_FFFF);
        run_until(730);
        wait_for_results();

        // only zero-length packets fit
        cfg_write(REG_MARK, 32'd0);
        cfg_write(REG_MAX_LEN, 32'd8);
        run_until(880);
        wait_for_results();

        idling = 1'b0;
        cfg_write(REG_MARK, $urandom);
        cfg_write(REG_MAX_LEN, 32'd0);
        run_until(980);
        wait_for_results();

        cfg_write(REG_MARK, $urandom);
        cfg_write(REG_MAX_LEN, $urandom_range(9, 40));
        run_until(1400);
        wait_for_results();
        repeat (8) @(posedge clk);

        if (sb.faults == 0 && sb.pending_results.size() == 0)
            $display("[length_prefixed_packet_deframer_core] OK");
        else
            $display("[length_prefixed_packet_deframer_core] ERROR");
        $finish;
    end

endmodule
